// ===== sv/positional_insert_delete_array_macros.svh =====
// Assertion macros for the positional insert/delete array.
// Included by the top level; relies on clk and rst_n in the including scope.
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define PIDA_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pida assertion failed");
// Next-cycle implication, checked outside reset.
`define PIDA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pida assertion failed");
`else
`define PIDA_ASSERT_IMPLY(lbl, ante, cons)
`define PIDA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/pida_pkg.sv =====
// Package for the positional insert/delete array: sizes, codes and payload types.
// Used by pida_ctrl and the top level; depends on nothing.
`timescale 1ns / 1ps
package pida_pkg;

    localparam int CAPACITY = 128;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]               operation;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        logic [1:0]               status;
        logic [7:0]               entry_count;
    } rsp_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_cmd_t;

endpackage

// ===== sv/pida_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// Stand-alone; depends on no package.
`timescale 1ns / 1ps
module pida_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/pida_ctrl.sv =====
// Sequencer for the positional insert/delete array: checks requests, walks the
// memory one entry per cycle to open or close a gap, and registers the result.
// Depends on pida_pkg.
`timescale 1ns / 1ps
module pida_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  pida_pkg::req_t            req,
    output logic                      busy,
    output logic                      done,
    output pida_pkg::rsp_t            rsp,
    output pida_pkg::mem_cmd_t        mem_cmd,
    input  logic [pida_pkg::DATA_W-1:0] rd_data
);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_SHIFT_UP  = 6'b000010,
        S_INS_LAST  = 6'b000100,
        S_DEL_HEAD  = 6'b001000,
        S_SHIFT_DN  = 6'b010000,
        S_READ_WAIT = 6'b100000
    } state_t;

    state_t                           state_reg, state_next;
    logic [pida_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [pida_pkg::CNT_W-1:0]       ptr_reg, ptr_next;
    logic [pida_pkg::CNT_W-1:0]       pos_reg, pos_next;
    logic signed [pida_pkg::DATA_W-1:0] value_reg, value_next;
    logic signed [pida_pkg::DATA_W-1:0] word_reg, word_next;
    logic                             done_reg, done_next;
    pida_pkg::rsp_t                   rsp_reg, rsp_next;

    logic [pida_pkg::CMP_W-1:0] pos_ext;
    logic [pida_pkg::CMP_W-1:0] cnt_ext;
    logic [pida_pkg::CMP_W-1:0] cnt_out;
    logic [pida_pkg::CNT_W-1:0] pos_cnt;
    logic [pida_pkg::CNT_W-1:0] cnt_dec;
    logic [pida_pkg::CNT_W-1:0] ptr_dec;
    logic [pida_pkg::CNT_W-1:0] ptr_dec2;
    logic [pida_pkg::CNT_W-1:0] ptr_inc;

    assign pos_ext  = pida_pkg::CMP_W'(req.position);
    assign cnt_ext  = pida_pkg::CMP_W'(count_reg);
    assign pos_cnt  = pos_ext[pida_pkg::CNT_W-1:0];
    assign cnt_dec  = count_reg - pida_pkg::CNT_W'(1);
    assign ptr_dec  = ptr_reg - pida_pkg::CNT_W'(1);
    assign ptr_dec2 = ptr_reg - pida_pkg::CNT_W'(2);
    assign ptr_inc  = ptr_reg + pida_pkg::CNT_W'(1);
    assign cnt_out  = pida_pkg::CMP_W'(count_next);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        pos_next   = pos_reg;
        value_next = value_reg;
        word_next  = word_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        mem_cmd    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    pos_next   = pos_cnt;
                    value_next = req.value;
                    case (req.operation)
                        pida_pkg::OP_INSERT:
                        begin
                            if (pos_ext > cnt_ext)
                            begin
                                done_next         = 1'b1;
                                rsp_next.data_out = '0;
                                rsp_next.status   = pida_pkg::ST_BADPOS;
                            end
                            else if (count_reg == pida_pkg::CAP_CNT)
                            begin
                                done_next         = 1'b1;
                                rsp_next.data_out = '0;
                                rsp_next.status   = pida_pkg::ST_FULL;
                            end
                            else if (pos_cnt == count_reg)
                            begin
                                // Append: no entries to move.
                                mem_cmd.we        = 1'b1;
                                mem_cmd.waddr     = pos_cnt[pida_pkg::ADDR_W-1:0];
                                mem_cmd.wdata     = req.value;
                                count_next        = count_reg + pida_pkg::CNT_W'(1);
                                done_next         = 1'b1;
                                rsp_next.data_out = '0;
                                rsp_next.status   = pida_pkg::ST_OK;
                            end
                            else
                            begin
                                mem_cmd.re    = 1'b1;
                                mem_cmd.raddr = cnt_dec[pida_pkg::ADDR_W-1:0];
                                ptr_next      = count_reg;
                                state_next    = S_SHIFT_UP;
                            end
                        end
                        pida_pkg::OP_DELETE:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                done_next         = 1'b1;
                                rsp_next.data_out = '0;
                                rsp_next.status   = pida_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                mem_cmd.re    = 1'b1;
                                mem_cmd.raddr = pos_cnt[pida_pkg::ADDR_W-1:0];
                                ptr_next      = pos_cnt + pida_pkg::CNT_W'(1);
                                state_next    = S_DEL_HEAD;
                            end
                        end
                        pida_pkg::OP_READ:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                done_next         = 1'b1;
                                rsp_next.data_out = '0;
                                rsp_next.status   = pida_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                mem_cmd.re    = 1'b1;
                                mem_cmd.raddr = pos_cnt[pida_pkg::ADDR_W-1:0];
                                state_next    = S_READ_WAIT;
                            end
                        end
                        default:
                        begin
                            done_next         = 1'b1;
                            rsp_next.data_out = '0;
                            rsp_next.status   = pida_pkg::ST_BADPOS;
                        end
                    endcase
                end
            end

            S_SHIFT_UP:
            begin
                // rd_data holds the entry just below ptr; move it up by one.
                mem_cmd.we    = 1'b1;
                mem_cmd.waddr = ptr_reg[pida_pkg::ADDR_W-1:0];
                mem_cmd.wdata = rd_data;
                ptr_next      = ptr_dec;
                if (ptr_dec == pos_reg)
                begin
                    state_next = S_INS_LAST;
                end
                else
                begin
                    mem_cmd.re    = 1'b1;
                    mem_cmd.raddr = ptr_dec2[pida_pkg::ADDR_W-1:0];
                end
            end

            S_INS_LAST:
            begin
                mem_cmd.we        = 1'b1;
                mem_cmd.waddr     = pos_reg[pida_pkg::ADDR_W-1:0];
                mem_cmd.wdata     = value_reg;
                count_next        = count_reg + pida_pkg::CNT_W'(1);
                done_next         = 1'b1;
                rsp_next.data_out = '0;
                rsp_next.status   = pida_pkg::ST_OK;
                state_next        = S_IDLE;
            end

            S_DEL_HEAD:
            begin
                word_next = rd_data;
                if (ptr_reg == count_reg)
                begin
                    count_next        = cnt_dec;
                    done_next         = 1'b1;
                    rsp_next.data_out = rd_data;
                    rsp_next.status   = pida_pkg::ST_OK;
                    state_next        = S_IDLE;
                end
                else
                begin
                    mem_cmd.re    = 1'b1;
                    mem_cmd.raddr = ptr_reg[pida_pkg::ADDR_W-1:0];
                    state_next    = S_SHIFT_DN;
                end
            end

            S_SHIFT_DN:
            begin
                // rd_data holds the entry at ptr; move it down by one.
                mem_cmd.we    = 1'b1;
                mem_cmd.waddr = ptr_dec[pida_pkg::ADDR_W-1:0];
                mem_cmd.wdata = rd_data;
                if (ptr_inc == count_reg)
                begin
                    count_next        = cnt_dec;
                    done_next         = 1'b1;
                    rsp_next.data_out = word_reg;
                    rsp_next.status   = pida_pkg::ST_OK;
                    state_next        = S_IDLE;
                end
                else
                begin
                    mem_cmd.re    = 1'b1;
                    mem_cmd.raddr = ptr_inc[pida_pkg::ADDR_W-1:0];
                    ptr_next      = ptr_inc;
                end
            end

            S_READ_WAIT:
            begin
                done_next         = 1'b1;
                rsp_next.data_out = rd_data;
                rsp_next.status   = pida_pkg::ST_OK;
                state_next        = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done_next)
        begin
            rsp_next.entry_count = cnt_out[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        pos_reg   <= pos_next;
        value_reg <= value_next;
        word_reg  <= word_next;
        rsp_reg   <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== sv/positional_insert_delete_array.sv =====
// Positional insert/delete array. With n entries held and position p, a request
// never raises busy on an error or an append; a read keeps busy high while the
// memory read completes, a delete or an insert while the entries between p and n move.
// The strobe is high in the cycle in which busy falls, or in the cycle after the request
// when busy never rises, and the next request is taken at the edge that takes the result.
// The single memory write port, moving one entry per cycle, sets how long busy lasts.
// The receiver cannot stall. Reset empties the array at once: the count clears and the
// memory contents are left untouched.
`timescale 1ns / 1ps
`include "positional_insert_delete_array_macros.svh"
module positional_insert_delete_array (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  pida_pkg::req_t req,
    output logic           busy,
    output logic           done,
    output pida_pkg::rsp_t rsp
);

    // The entries live in one simple dual-port memory. The sequencer reads
    // one entry ahead of the entry it writes, so a read and a write never
    // target the same address in one cycle and no forwarding is required:
    // an insert walks downwards from the top of the array, a delete upwards
    // from just above the removed position.
    pida_pkg::mem_cmd_t              mem_cmd;
    logic [pida_pkg::DATA_W-1:0]     rd_data;

    pida_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .busy    (busy),
        .done    (done),
        .rsp     (rsp),
        .mem_cmd (mem_cmd),
        .rd_data (rd_data)
    );

    // Entries that were never written hold no defined value; the count
    // guarantees that only written entries are ever read back.
    pida_ram #(
        .DEPTH (pida_pkg::CAPACITY),
        .WIDTH (pida_pkg::DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_cmd.we),
        .waddr (mem_cmd.waddr),
        .wdata (mem_cmd.wdata),
        .re    (mem_cmd.re),
        .raddr (mem_cmd.raddr),
        .rdata (rd_data)
    );

    // A read and a write in the same cycle must always address different entries.
    `PIDA_ASSERT_IMPLY(a_no_rw_collision, mem_cmd.re && mem_cmd.we, mem_cmd.raddr != mem_cmd.waddr)
    // Every accepted request either starts work or answers in the next cycle.
    `PIDA_ASSERT_NEXT(a_request_progress, start && !busy, busy || done)
    // A result is only ever presented once the sequencer is back at rest.
    `PIDA_ASSERT_IMPLY(a_done_when_idle, done, !busy)
    // A failed request never returns data.
    `PIDA_ASSERT_IMPLY(a_error_zero_data, done && (rsp.status != pida_pkg::ST_OK), rsp.data_out == '0)

endmodule

// ===== tb/pida_checker.sv =====
// Checker for the positional insert/delete array: shadows the array, predicts each result.
// Depends on pida_pkg; watches the request and response channels of the block.
`timescale 1ns / 1ps
module pida_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  logic           done,
    input  pida_pkg::req_t req,
    input  pida_pkg::rsp_t rsp,
    output int             mismatch_count,
    output int             outstanding,
    output int             model_count
);
    import pida_pkg::*;

    // Shadow copy of the array contents and of the entry count.
    logic signed [DATA_W-1:0] shadow_words [CAPACITY];
    int                       held = 0;
    int                       fail_tally = 0;
    rsp_t                     expected_rsp [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] pida mismatch: %s", $time, msg);
        fail_tally++;
    endtask

    // Applies one request to the shadow array and returns the response it should give.
    function automatic rsp_t apply_array_op(input req_t r);
        rsp_t res;
        int   p;
        int   i;
        res.data_out = '0;
        res.status   = ST_OK;
        p = int'(r.position);
        case (r.operation)
            OP_INSERT:
            begin
                if (p > held)
                begin
                    res.status = ST_BADPOS;
                end
                else if (held >= CAPACITY)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    for (i = held; i > p; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[p] = r.value;
                    held++;
                end
            end
            OP_DELETE:
            begin
                if (p >= held)
                begin
                    res.status = ST_BADPOS;
                end
                else
                begin
                    res.data_out = shadow_words[p];
                    for (i = p + 1; i < held; i++)
                        shadow_words[i-1] = shadow_words[i];
                    held--;
                end
            end
            OP_READ:
            begin
                if (p >= held)
                    res.status = ST_BADPOS;
                else
                    res.data_out = shadow_words[p];
            end
            default:
            begin
                res.status = ST_BADPOS;
            end
        endcase
        res.entry_count = 8'(held);
        return res;
    endfunction

    task automatic check_result(input rsp_t got);
        rsp_t want;
        if (expected_rsp.size() == 0)
        begin
            report_mismatch("response strobe with no request outstanding");
            return;
        end
        want = expected_rsp.pop_front();
        if (got.data_out !== want.data_out)
            report_mismatch($sformatf("data_out %0d, expected %0d",
                                      got.data_out, want.data_out));
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      got.entry_count, want.entry_count));
    endtask

    // The response is compared before a request taken on the same edge is queued,
    // so the strobe always meets the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_rsp.delete();
            held = 0;
            fail_tally = 0;
            outstanding    <= 0;
            model_count    <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (done)
                check_result(rsp);
            if (start && !busy)
                expected_rsp.push_back(apply_array_op(req));
            outstanding    <= expected_rsp.size();
            model_count    <= held;
            mismatch_count <= fail_tally;
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the positional insert/delete array: clock, reset, stimulus and verdict.
// Depends on pida_pkg, the block itself and pida_checker, which does all the checking.
`timescale 1ns / 1ps
module tb_top;
    import pida_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 6;
    localparam int RANDOM_REQUESTS = 850;
    // Bound on the whole run: even with every request at its longest and every sender
    // gap at MAX_GAP, all the requests finish well inside this limit.
    localparam int CYCLE_LIMIT     = 800_000;
    // Quiet time after the last result.
    localparam int DRAIN_CYCLES    = 2 * CAPACITY + 8;
    localparam int MAX_GAP         = 17;

    // Operation code the block does not define; it must be rejected as a bad position.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    req_t req;
    rsp_t rsp;

    int   mismatch_count;
    int   outstanding;
    int   model_count;
    int   cycle_count = 0;

    // When set, requests follow one another with no gap at all.
    logic burst_mode = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    positional_insert_delete_array u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    pida_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .done           (done),
        .req            (req),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .model_count    (model_count)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** positional_insert_delete_array: FAILED **");
            $finish;
        end
    end

    // Presents one request after a random idle gap and returns once the block has
    // taken it, that is after an edge at which start was high and busy low. When
    // there is no gap, start simply stays high from the previous request, so it is
    // never dropped and raised again within one time step.
    task automatic send_request(input logic [1:0] op, input logic [POS_W-1:0] pos,
                                input logic signed [DATA_W-1:0] val);
        int gap;
        gap = burst_mode ? 0 : int'($urandom_range(0, MAX_GAP));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= '{operation: op, position: pos, value: val};
        do
            @(posedge clk);
        while (busy);
    endtask

    initial
    begin
        int                       n;
        int                       roll;
        logic                     filling;
        logic [1:0]               op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;

        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests. First every kind of request on an empty array, all of
        // which must be rejected.
        send_request(OP_READ,   8'd0,   32'sd0);
        send_request(OP_DELETE, 8'd0,   32'sd0);
        send_request(OP_INSERT, 8'd1,   32'sd5);
        send_request(OP_UNUSED, 8'd0,   32'sd7);
        // Build a short array: append, append, insert at the front, insert in the middle.
        send_request(OP_INSERT, 8'd0,   WORD_MAX);
        send_request(OP_INSERT, 8'd1,   WORD_MIN);
        send_request(OP_INSERT, 8'd0,   -32'sd1);
        send_request(OP_INSERT, 8'd1,   32'sd0);
        // Reads at both ends, at the count itself and at the top of the position range.
        send_request(OP_READ,   8'd0,   32'sd0);
        send_request(OP_READ,   8'd3,   32'sd0);
        send_request(OP_READ,   8'd4,   32'sd0);
        send_request(OP_READ,   8'd255, 32'sd0);
        // Rejected deletes and inserts beyond the valid range: just past its end and at its top.
        send_request(OP_DELETE, 8'd4,   32'sd0);
        send_request(OP_INSERT, 8'd255, 32'sh1234_5678);
        send_request(OP_INSERT, 8'd5,   32'sh1234_5678);
        // Deletes from the middle and from the end, then a read of what moved down.
        send_request(OP_DELETE, 8'd1,   32'sd0);
        send_request(OP_DELETE, 8'd2,   32'sd0);
        send_request(OP_READ,   8'd1,   32'sd0);
        send_request(OP_UNUSED, 8'd0,   WORD_MIN);
        // Empty the array again and insert into it once more.
        send_request(OP_DELETE, 8'd0,   32'sd0);
        send_request(OP_DELETE, 8'd0,   32'sd0);
        send_request(OP_INSERT, 8'd0,   32'sh5555_5555);

        // Random requests. The run alternates between filling the array, which is
        // where the full case and the long shifts live, and draining it towards
        // empty. Positions are mostly valid for the current count, with the count
        // itself, zero and the whole 8-bit range mixed in. The count the stimulus
        // sees can lag one request behind; that only shifts the odds a little.
        filling = 1'b1;
        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 32 == 0)
                burst_mode = ($urandom_range(0, 2) == 0);
            if (filling && model_count >= CAPACITY && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (!filling && model_count == 0 && $urandom_range(0, 3) == 0)
                filling = 1'b1;

            roll = int'($urandom_range(0, 99));
            if (roll < 4)
                op = OP_UNUSED;
            else if (roll < (filling ? 70 : 15))
                op = OP_INSERT;
            else if (roll < (filling ? 85 : 75))
                op = OP_DELETE;
            else
                op = OP_READ;

            roll = int'($urandom_range(0, 99));
            if (roll < 10)
                pos = POS_W'($urandom_range(0, 255));
            else if (roll < 20)
                pos = POS_W'(model_count);
            else if (roll < 25)
                pos = '0;
            else if (op == OP_INSERT)
                pos = POS_W'($urandom_range(0, model_count));
            else
                pos = (model_count > 0) ? POS_W'($urandom_range(0, model_count - 1)) : '0;

            roll = int'($urandom_range(0, 99));
            if (roll < 3)
                val = WORD_MAX;
            else if (roll < 6)
                val = WORD_MIN;
            else if (roll < 8)
                val = '0;
            else if (roll < 10)
                val = -32'sd1;
            else
                val = $urandom;

            send_request(op, pos, val);
        end
        start <= 1'b0;

        // The checker's outstanding count is registered at the edge that takes the last
        // request, hence the wait for an edge before it is looked at.
        do
            @(posedge clk);
        while (outstanding != 0);
        // Give any stray strobe time to show itself before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("** positional_insert_delete_array: PASSED **");
        else
            $display("** positional_insert_delete_array: FAILED **");
        $finish;
    end

endmodule
